@@ sv/rts_pkg.sv @@
`default_nettype none

package rts_pkg;

  localparam int unsigned NUM_SLOTS = 3;
  localparam int unsigned NUM_CFG   = 6;

  localparam int unsigned TIME_W  = 64;
  localparam int unsigned ROUND_W = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned STEP_W  = 2;
  localparam int unsigned FUNC_W  = 2;

  typedef logic [FUNC_W-1:0]  func_t;
  typedef logic [STEP_W-1:0]  step_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [ROUND_W-1:0] round_t;
  typedef logic [CFG_W-1:0]   cfg_word_t;

  // Operation codes carried in the input tuser.
  localparam func_t FUNC_SCHEDULE = 2'd0;
  localparam func_t FUNC_TAKE     = 2'd1;
  localparam func_t FUNC_CLEAR    = 2'd2;

  // Consensus steps; each valid step owns one timer slot.
  localparam step_t STEP_PROPOSE   = 2'd0;
  localparam step_t STEP_PREVOTE   = 2'd1;
  localparam step_t STEP_PRECOMMIT = 2'd2;
  localparam step_t STEP_INVALID   = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_PROPOSE_BASE     = 3'd0;
  localparam logic [2:0] REG_PROPOSE_GROWTH   = 3'd1;
  localparam logic [2:0] REG_PREVOTE_BASE     = 3'd2;
  localparam logic [2:0] REG_PREVOTE_GROWTH   = 3'd3;
  localparam logic [2:0] REG_PRECOMMIT_BASE   = 3'd4;
  localparam logic [2:0] REG_PRECOMMIT_GROWTH = 3'd5;

  // Reset values of the timing registers, in milliseconds.
  localparam cfg_word_t RST_PROPOSE_BASE   = 32'd3000;
  localparam cfg_word_t RST_PREVOTE_BASE   = 32'd1000;
  localparam cfg_word_t RST_PRECOMMIT_BASE = 32'd1000;
  localparam cfg_word_t RST_GROWTH         = 32'd500;

endpackage

`default_nettype wire

@@ sv/round_timeout_slots.sv @@
`default_nettype none

// Three one-shot consensus timers, one for each step (propose, prevote,
// precommit). A schedule transaction arms the step's slot with a deadline of
// now_ms + base + round * growth, saturated at all ones, and returns that
// deadline; a take transaction disarms and returns the first expired armed
// slot in the order propose, prevote, precommit; a clear transaction disarms
// every slot. Every input transaction yields exactly one output transaction.
// The block works on one transaction at a time: all arithmetic goes through
// a single 32x32 multiplier stage and one shared 64-bit adder under a small
// sequencer. A schedule goes from acceptance to the result register through
// the steps multiply, add base, add current time and output; a take compares
// one slot per cycle in the shared adder, then outputs; a clear, an invalid
// step or an unused operation goes straight to output. in_tready is high
// only while the sequencer is idle, which it reaches again as the result is
// loaded. A finished result sits in the output register and the next
// transaction may be accepted and worked on while it waits; a result that
// cannot be loaded holds the sequencer in its output state and so stalls
// the input.
// Configuration writes are taken at any time but must only be issued while
// the block is idle.
module round_timeout_slots (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input stream.
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // tdata from bit 0: height[63:0], round_number[95:64], now_ms[159:96]
  input  wire logic [159:0]                   in_tdata,
  // tuser from bit 0: func[1:0], step_kind[3:2]
  input  wire logic [3:0]                     in_tuser,
  // Result stream.
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // tdata from bit 0: fired_height[63:0], fired_round[95:64], deadline_set[159:96]
  output logic [159:0]                        out_tdata,
  // tuser from bit 0: fired[0], fired_step[2:1]
  output logic [2:0]                          out_tuser,
  // Configuration write port.
  input  wire logic                           cfg_we,
  input  wire logic [2:0]                     cfg_addr,
  input  wire logic [rts_pkg::CFG_W-1:0]      cfg_wdata
);

  import rts_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_ADD_T = 3'd2;
  localparam logic [2:0] ST_ADD_D = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  localparam step_t LAST_SLOT = step_t'(NUM_SLOTS - 1);

  logic [2:0] state_r, state_nxt;

  // Timing registers, split so that each bank is read at a single address.
  cfg_word_t base_r   [NUM_SLOTS];
  cfg_word_t growth_r [NUM_SLOTS];

  // Slot store.
  logic [NUM_SLOTS-1:0] armed_r;
  time_t                slot_height_r   [NUM_SLOTS];
  round_t               slot_round_r    [NUM_SLOTS];
  time_t                slot_deadline_r [NUM_SLOTS];

  // Captured transaction.
  step_t  kind_r;
  time_t  height_r;
  round_t rnd_r;
  time_t  now_r;

  // Working registers.
  time_t  acc_r;      // product, then timeout, then deadline
  step_t  idx_r;      // slot under comparison during a take
  logic   hit_r;      // take found an expired slot at idx_r
  logic   sched_r;    // schedule with a valid step

  logic         out_tvalid_r;
  logic [159:0] out_tdata_r;
  logic [2:0]   out_tuser_r;

  logic  in_fire;
  logic  out_load;
  func_t in_func;
  step_t in_kind;

  // Shared arithmetic: one 64-bit adder with carry in and carry out.
  time_t       add_a, add_b;
  logic        add_cin;
  logic [64:0] add_sum;
  time_t       prod;

  assign in_func = in_tuser[1:0];
  assign in_kind = in_tuser[3:2];
  assign in_fire = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign out_load = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);

  // Round times growth: both operands are 32 bits wide, zero-extended so
  // that the full 64-bit product is kept.
  assign prod = time_t'(rnd_r) * time_t'(growth_r[kind_r]);

  always_comb begin
    add_a   = now_r;
    add_b   = acc_r;
    add_cin = 1'b0;
    case (state_r)
      ST_ADD_T: begin
        add_a = time_t'(base_r[kind_r]);
        add_b = acc_r;
      end
      ST_ADD_D: begin
        add_a = now_r;
        add_b = acc_r;
      end
      ST_SCAN: begin
        // now - deadline: a carry out means the deadline is at or before now.
        add_a   = now_r;
        add_b   = ~slot_deadline_r[idx_r];
        add_cin = 1'b1;
      end
      default: begin
        add_a   = now_r;
        add_b   = acc_r;
        add_cin = 1'b0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + 65'(add_cin);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_func == FUNC_SCHEDULE && in_kind != STEP_INVALID) begin
            state_nxt = ST_MUL;
          end else if (in_func == FUNC_TAKE) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end
      ST_MUL:   state_nxt = ST_ADD_T;
      ST_ADD_T: state_nxt = ST_ADD_D;
      ST_ADD_D: state_nxt = ST_OUT;
      ST_SCAN: begin
        if ((armed_r[idx_r] && add_sum[64]) || idx_r == LAST_SLOT) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      armed_r      <= '0;
      out_tvalid_r <= 1'b0;
      base_r[0]    <= RST_PROPOSE_BASE;
      base_r[1]    <= RST_PREVOTE_BASE;
      base_r[2]    <= RST_PRECOMMIT_BASE;
      growth_r[0]  <= RST_GROWTH;
      growth_r[1]  <= RST_GROWTH;
      growth_r[2]  <= RST_GROWTH;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        case (cfg_addr)
          REG_PROPOSE_BASE:     base_r[0]   <= cfg_wdata;
          REG_PROPOSE_GROWTH:   growth_r[0] <= cfg_wdata;
          REG_PREVOTE_BASE:     base_r[1]   <= cfg_wdata;
          REG_PREVOTE_GROWTH:   growth_r[1] <= cfg_wdata;
          REG_PRECOMMIT_BASE:   base_r[2]   <= cfg_wdata;
          REG_PRECOMMIT_GROWTH: growth_r[2] <= cfg_wdata;
          default: begin
          end
        endcase
      end

      // Clearing only disarms: slot contents are never read while disarmed.
      if (state_r == ST_IDLE && in_fire && in_func == FUNC_CLEAR) begin
        armed_r <= '0;
      end
      if (state_r == ST_ADD_D) begin
        armed_r[kind_r] <= 1'b1;
      end
      if (state_r == ST_SCAN && armed_r[idx_r] && add_sum[64]) begin
        armed_r[idx_r] <= 1'b0;
      end

      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r   <= in_kind;
      height_r <= in_tdata[63:0];
      rnd_r    <= in_tdata[95:64];
      now_r    <= in_tdata[159:96];
      idx_r    <= STEP_PROPOSE;
      hit_r    <= 1'b0;
      sched_r  <= (in_func == FUNC_SCHEDULE) && (in_kind != STEP_INVALID);
    end
    case (state_r)
      ST_MUL:   acc_r <= prod;
      ST_ADD_T: acc_r <= add_sum[63:0];
      ST_ADD_D: begin
        acc_r                   <= add_sum[64] ? '1 : add_sum[63:0];
        slot_height_r[kind_r]   <= height_r;
        slot_round_r[kind_r]    <= rnd_r;
        slot_deadline_r[kind_r] <= add_sum[64] ? '1 : add_sum[63:0];
      end
      ST_SCAN: begin
        if (armed_r[idx_r] && add_sum[64]) begin
          hit_r <= 1'b1;
        end else if (idx_r != LAST_SLOT) begin
          idx_r <= idx_r + step_t'(1);
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_tdata_r[63:0]    <= hit_r ? slot_height_r[idx_r] : '0;
      out_tdata_r[95:64]   <= hit_r ? slot_round_r[idx_r] : '0;
      out_tdata_r[159:96]  <= sched_r ? acc_r : '0;
      out_tuser_r[0]       <= hit_r;
      out_tuser_r[2:1]     <= hit_r ? idx_r : STEP_PROPOSE;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // A clear leaves no slot armed.
  a_clear_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_func == FUNC_CLEAR) |=> (armed_r == '0))
    else $error("slot still armed after clear");

  // A schedule arms the slot of its step.
  a_schedule_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADD_D) |=> armed_r[$past(kind_r)])
    else $error("scheduled slot not armed");

  // A fired result never names the invalid step.
  a_fired_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tuser[2:1] != STEP_INVALID))
    else $error("fired result names an invalid step");

  // The scan stays within the slots.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r != STEP_INVALID))
    else $error("scan index out of range");

  // A result is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> !$past(out_load))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

// Self-checking bench for the three-slot consensus timer. A predictor kept
// here mirrors the slot contents and the six timing registers and works out
// the result of every input transaction at the edge where it is accepted;
// each output transaction is compared field by field with the oldest
// outstanding prediction. A short directed table comes first, followed by
// random traffic under several timing settings, with both streams throttled.
module testbench;
  import rts_pkg::*;

  // The fourth operation code is undefined and the block must ignore it.
  localparam func_t FUNC_UNUSED = 2'd3;

  localparam time_t  T_MAX = '1;
  localparam round_t R_MAX = '1;

  // One output transaction: fired flag, step, height, round and deadline.
  typedef struct packed {
    logic   fired;
    step_t  step;
    time_t  height;
    round_t rnd;
    time_t  deadline;
  } timer_result_t;

  // A schedule at round zero, time zero, with the registers at reset.
  localparam timer_result_t PROPOSE_AT_RESET =
    '{1'b0, STEP_PROPOSE, '0, '0, time_t'(RST_PROPOSE_BASE)};
  // A schedule whose deadline ran past the top of the time range.
  localparam timer_result_t SATURATED = '{1'b0, STEP_PROPOSE, '0, '0, '1};

  // A row of the directed table. Where `typed` is set the expected result
  // is written in the row itself, otherwise the predictor supplies it.
  typedef struct {
    func_t         op;
    step_t         st;
    time_t         ht;
    round_t        rn;
    time_t         now;
    bit            typed;
    timer_result_t res;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [159:0]         in_tdata   = '0;
  logic [3:0]           in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [159:0]         out_tdata;
  logic [2:0]           out_tuser;
  logic                 cfg_we     = 1'b0;
  logic [2:0]           cfg_addr   = '0;
  logic [CFG_W-1:0]     cfg_wdata  = '0;

  // Predictor state: timing registers and the contents of the three slots.
  cfg_word_t timing_reg [NUM_CFG];
  logic      slot_on    [NUM_SLOTS];
  time_t     slot_ht    [NUM_SLOTS];
  round_t    slot_rnd   [NUM_SLOTS];
  time_t     slot_due   [NUM_SLOTS];

  timer_result_t pending_results [$];
  stim_row_t     directed_rows   [$];
  int            mismatch_count = 0;

  // When set, the corresponding side runs flat out with no gaps or stalls.
  bit steady_input  = 1'b0;
  bit steady_output = 1'b0;
  int ready_hold    = 0;
  int ready_roll;

  // Free-running notion of the current time used by the random traffic, and
  // a slowly rising height so that most schedules look like a real chain.
  time_t clock_ms;
  time_t chain_height;

  round_timeout_slots i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard cap on the run: far beyond the slowest legal completion, in which
  // every transaction meets the longest input gap and output stall.
  initial begin
    #12_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void clear_slot_model();
    for (int s = 0; s < NUM_SLOTS; s++) begin
      slot_on[s]  = 1'b0;
      slot_ht[s]  = '0;
      slot_rnd[s] = '0;
      slot_due[s] = '0;
    end
  endfunction

  // Works out the result of one accepted transaction and updates the slots.
  function automatic timer_result_t predict_result(func_t op, step_t st, time_t ht,
                                                   round_t rn, time_t now);
    timer_result_t r;
    time_t         span;
    time_t         due;
    r = '0;
    case (op)
      FUNC_SCHEDULE: begin
        if (st != STEP_INVALID) begin
          // base + round * growth always fits in 64 bits, so it is exact.
          span = time_t'(timing_reg[2*st]) + time_t'(rn) * time_t'(timing_reg[2*st+1]);
          due  = (span > ~now) ? T_MAX : now + span;
          slot_on[st]  = 1'b1;
          slot_ht[st]  = ht;
          slot_rnd[st] = rn;
          slot_due[st] = due;
          r.deadline   = due;
        end
      end
      FUNC_TAKE: begin
        // Fixed priority: propose, then prevote, then precommit.
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if (!r.fired && slot_on[s] && slot_due[s] <= now) begin
            slot_on[s] = 1'b0;
            r.fired    = 1'b1;
            r.step     = step_t'(s);
            r.height   = slot_ht[s];
            r.rnd      = slot_rnd[s];
          end
        end
      end
      FUNC_CLEAR: clear_slot_model();
      default: ;
    endcase
    return r;
  endfunction

  // Presents one transaction and waits for the handshake; the prediction is
  // made at the very edge at which the block takes it.
  task automatic send_item(func_t op, step_t st, time_t ht, round_t rn, time_t now,
                           output timer_result_t predicted);
    in_tvalid <= 1'b1;
    in_tuser  <= {st, op};
    in_tdata  <= {now, rn, ht};
    do @(posedge clk); while (!in_tready);
    predicted = predict_result(op, st, ht, rn, now);
  endtask

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int pick_gap();
    int p;
    if (steady_input) return 0;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  task automatic hold_off_input();
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and lets every outstanding result come back. Each
  // transaction yields exactly one result, so an empty store means idle;
  // the extra cycles cover the sequencer returning to its idle state.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, cfg_word_t value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    timing_reg[idx] = value;
    @(posedge clk);
  endtask

  task automatic load_timing(cfg_word_t pb, cfg_word_t pg, cfg_word_t vb,
                             cfg_word_t vg, cfg_word_t cb, cfg_word_t cg);
    write_reg(REG_PROPOSE_BASE, pb);
    write_reg(REG_PROPOSE_GROWTH, pg);
    write_reg(REG_PREVOTE_BASE, vb);
    write_reg(REG_PREVOTE_GROWTH, vg);
    write_reg(REG_PRECOMMIT_BASE, cb);
    write_reg(REG_PRECOMMIT_GROWTH, cg);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic: mostly schedules and takes against a clock that creeps
  // forward by up to `stride` per transaction, so slots both arm and expire,
  // with occasional clears, ignored codes and wild or saturated times.
  task automatic run_random(int count, time_t stride);
    func_t         op;
    step_t         st;
    time_t         ht;
    round_t        rn;
    time_t         now;
    timer_result_t predicted;
    int            pick;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        steady_input  = ($urandom_range(0, 3) == 0);
        steady_output = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 47)      op = FUNC_SCHEDULE;
      else if (pick < 94) op = FUNC_TAKE;
      else if (pick < 98) op = FUNC_CLEAR;
      else                op = FUNC_UNUSED;
      st = ($urandom_range(0, 9) == 0) ? STEP_INVALID : step_t'($urandom_range(0, 2));

      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        now = {$urandom, $urandom};
      end else if (pick < 5) begin
        now = T_MAX;
      end else begin
        clock_ms = clock_ms + ({$urandom, $urandom} % (stride + 1));
        now = clock_ms;
      end

      if ($urandom_range(0, 99) < 70) begin
        ht = chain_height;
        chain_height = chain_height + time_t'($urandom_range(0, 1));
      end else begin
        ht = {$urandom, $urandom};
      end

      pick = $urandom_range(0, 99);
      if (pick < 75)      rn = round_t'($urandom_range(0, 8));
      else if (pick < 90) rn = round_t'($urandom_range(0, 1000));
      else                rn = $urandom;

      send_item(op, st, ht, rn, now, predicted);
      pending_results.push_back(predicted);
      hold_off_input();
    end
  endtask

  // Output side back-pressure: random levels held for random spells.
  always @(posedge clk) begin
    if (!rst_n || steady_output) begin
      out_tready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 60) begin
        out_tready <= 1'b1;
        ready_hold <= $urandom_range(0, 8);
      end else if (ready_roll < 95) begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(15, 50);
      end
    end
  end

  // Result checker: every accepted output transaction is matched against the
  // oldest prediction still waiting.
  always @(posedge clk) begin : check_results
    timer_result_t got;
    timer_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tuser[2:1], out_tdata[63:0], out_tdata[95:64],
             out_tdata[159:96]};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, got %h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.fired !== want.fired) begin
          $display("%0t: fired expected %0d, got %0d", $time, want.fired, got.fired);
          mismatch_count++;
        end
        if (got.step !== want.step) begin
          $display("%0t: fired_step expected %0d, got %0d", $time, want.step, got.step);
          mismatch_count++;
        end
        if (got.height !== want.height) begin
          $display("%0t: fired_height expected %h, got %h", $time, want.height, got.height);
          mismatch_count++;
        end
        if (got.rnd !== want.rnd) begin
          $display("%0t: fired_round expected %h, got %h", $time, want.rnd, got.rnd);
          mismatch_count++;
        end
        if (got.deadline !== want.deadline) begin
          $display("%0t: deadline_set expected %h, got %h", $time, want.deadline,
                   got.deadline);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    timer_result_t predicted;
    stim_row_t     row;

    timing_reg[REG_PROPOSE_BASE]     = RST_PROPOSE_BASE;
    timing_reg[REG_PROPOSE_GROWTH]   = RST_GROWTH;
    timing_reg[REG_PREVOTE_BASE]     = RST_PREVOTE_BASE;
    timing_reg[REG_PREVOTE_GROWTH]   = RST_GROWTH;
    timing_reg[REG_PRECOMMIT_BASE]   = RST_PRECOMMIT_BASE;
    timing_reg[REG_PRECOMMIT_GROWTH] = RST_GROWTH;
    clear_slot_model();
    clock_ms     = '0;
    chain_height = 64'd1;

    // Directed table, run with the registers at their reset values.
    // A take straight after reset finds nothing armed.
    directed_rows.push_back('{FUNC_TAKE, STEP_PROPOSE, '0, '0, '0, 1'b1, '0});
    // Round zero at time zero: the deadline is just the propose base.
    directed_rows.push_back('{FUNC_SCHEDULE, STEP_PROPOSE, '0, '0, '0, 1'b1,
                              PROPOSE_AT_RESET});
    // Largest round and height: the widest product of round and growth.
    directed_rows.push_back('{FUNC_SCHEDULE, STEP_PREVOTE, T_MAX, R_MAX, '0, 1'b0, '0});
    // Scheduling at the top of the time range saturates the deadline.
    directed_rows.push_back('{FUNC_SCHEDULE, STEP_PRECOMMIT, 64'h5555_5555_5555_5555,
                              32'd1, T_MAX, 1'b1, SATURATED});
    // An invalid step stores nothing and reports nothing.
    directed_rows.push_back('{FUNC_SCHEDULE, STEP_INVALID, T_MAX, R_MAX, T_MAX, 1'b1, '0});
    // One millisecond short of the propose deadline: nothing has expired.
    directed_rows.push_back('{FUNC_TAKE, STEP_PROPOSE, '0, '0,
                              time_t'(RST_PROPOSE_BASE) - 64'd1, 1'b1, '0});
    // Exactly at the deadline the propose slot fires, and only once.
    directed_rows.push_back('{FUNC_TAKE, STEP_PROPOSE, '0, '0,
                              time_t'(RST_PROPOSE_BASE), 1'b0, '0});
    directed_rows.push_back('{FUNC_TAKE, STEP_PROPOSE, '0, '0,
                              time_t'(RST_PROPOSE_BASE), 1'b1, '0});
    // At the end of time the remaining slots drain in priority order.
    directed_rows.push_back('{FUNC_TAKE, STEP_PRECOMMIT, '0, '0, T_MAX, 1'b0, '0});
    directed_rows.push_back('{FUNC_TAKE, STEP_PREVOTE, '0, '0, T_MAX, 1'b0, '0});
    directed_rows.push_back('{FUNC_TAKE, STEP_PROPOSE, '0, '0, T_MAX, 1'b1, '0});
    // Alternating bit patterns through every data field.
    directed_rows.push_back('{FUNC_SCHEDULE, STEP_PROPOSE, 64'hAAAA_AAAA_AAAA_AAAA,
                              32'hAAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0});
    directed_rows.push_back('{FUNC_SCHEDULE, STEP_PREVOTE, 64'h5555_5555_5555_5555,
                              32'h5555_5555, 64'h5555_5555_5555_5555, 1'b0, '0});
    // Clear disarms both slots, so even the end of time finds nothing.
    directed_rows.push_back('{FUNC_CLEAR, STEP_INVALID, T_MAX, R_MAX, T_MAX, 1'b1, '0});
    directed_rows.push_back('{FUNC_TAKE, STEP_PROPOSE, '0, '0, T_MAX, 1'b1, '0});
    // The undefined operation code changes nothing and reports nothing.
    directed_rows.push_back('{FUNC_UNUSED, STEP_INVALID, T_MAX, R_MAX, T_MAX, 1'b1, '0});
    directed_rows.push_back('{FUNC_SCHEDULE, STEP_PROPOSE, 64'd7, '0, T_MAX, 1'b1,
                              SATURATED});
    directed_rows.push_back('{FUNC_TAKE, STEP_PROPOSE, '0, '0, T_MAX, 1'b0, '0});
    // Both propose and precommit expired: propose wins the first take.
    directed_rows.push_back('{FUNC_SCHEDULE, STEP_PRECOMMIT, 64'd1, 32'd2, 64'd10,
                              1'b0, '0});
    directed_rows.push_back('{FUNC_SCHEDULE, STEP_PROPOSE, '0, '0, '0, 1'b1,
                              PROPOSE_AT_RESET});
    directed_rows.push_back('{FUNC_TAKE, STEP_PROPOSE, '0, '0, 64'd5000, 1'b0, '0});
    directed_rows.push_back('{FUNC_TAKE, STEP_PROPOSE, '0, '0, 64'd5000, 1'b0, '0});
    directed_rows.push_back('{FUNC_TAKE, STEP_PROPOSE, '0, '0, 64'd5000, 1'b1, '0});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      send_item(row.op, row.st, row.ht, row.rn, row.now, predicted);
      pending_results.push_back(row.typed ? row.res : predicted);
      hold_off_input();
    end

    // Registers at reset values, time moving in second-sized strides.
    run_random(250, 64'd4000);
    drain();

    // All zero: every deadline equals the current time and expires at once.
    load_timing('0, '0, '0, '0, '0, '0);
    run_random(280, 64'd20);
    drain();

    // All ones: the longest timeouts, so the clock has to leap to catch up.
    load_timing('1, '1, '1, '1, '1, '1);
    run_random(250, 64'h2_0000_0000);
    drain();

    // Modest random values, the usual operating region.
    load_timing($urandom_range(0, 5000), $urandom_range(0, 1000),
                $urandom_range(0, 5000), $urandom_range(0, 1000),
                $urandom_range(0, 5000), $urandom_range(0, 1000));
    run_random(300, 64'd3000);
    drain();

    // Random values over the full register width.
    load_timing($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    run_random(250, 64'h1_0000_0000);
    drain();

    // Back to the reset values, written explicitly this time.
    load_timing(RST_PROPOSE_BASE, RST_GROWTH, RST_PREVOTE_BASE, RST_GROWTH,
                RST_PRECOMMIT_BASE, RST_GROWTH);
    run_random(320, 64'd4000);
    drain();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
